[design/tea_pkg.sv]
// Shared types, constants and round functions for the 64-bit TEA-style cipher.
// No dependencies; every other design file imports this package.
`default_nettype none

package tea_pkg;

  // Default number of cipher rounds and the per-round sum increment.
  localparam int unsigned TEA_ROUNDS = 32;
  localparam logic [63:0] TEA_DELTA  = 64'h0123_4578_9876_5432;

  // Operation codes carried with each item.
  typedef enum logic {
    TEA_OP_ENCRYPT = 1'b0,
    TEA_OP_DECRYPT = 1'b1
  } tea_op_t;

  // Input item as it arrives on the input channel.
  typedef struct packed {
    tea_op_t     op;
    logic [63:0] first_half;
    logic [63:0] second_half;
  } tea_in_t;

  // Result item as it leaves on the output channel.
  typedef struct packed {
    logic [63:0] out_first;
    logic [63:0] out_second;
  } tea_out_t;

  // Item state carried between pipeline stages.
  typedef struct packed {
    tea_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } tea_stage_t;

  // Running sum after a given number of delta additions, modulo 2^64.
  function automatic logic [63:0] tea_sum(input int unsigned count);
    logic [63:0] product;
    product = TEA_DELTA * 64'(count);
    return product;
  endfunction

  // Round term: three parallel adds folded together with xor.
  function automatic logic [63:0] tea_term(input logic [63:0] w,
                                           input logic [63:0] sum,
                                           input logic [63:0] key);
    logic [63:0] t_shl;
    logic [63:0] t_sum;
    logic [63:0] t_shr;
    t_shl = (w << 4) + key;
    t_sum = w + sum;
    t_shr = (w >> 5) + key;
    return t_shl ^ t_sum ^ t_shr;
  endfunction

endpackage

`default_nettype wire

[design/tea_half_round.sv]
// One pipeline stage of the cipher: half of one round, updating one word.
// Depends on tea_pkg for the stage type, the round term and the sum constants.
`default_nettype none

module tea_half_round
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS    = TEA_ROUNDS,
  parameter int unsigned ROUND_IDX = 0,
  parameter bit          SECOND    = 1'b0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [63:0] key,
  input  wire logic        in_valid,
  input  wire tea_stage_t  in_data,
  output logic             out_valid,
  output tea_stage_t       out_data
);

  // Encryption uses the sum after ROUND_IDX+1 deltas; decryption walks back.
  localparam logic [63:0] SUM_ENC = tea_sum(ROUND_IDX + 1);
  localparam logic [63:0] SUM_DEC = tea_sum(ROUNDS - ROUND_IDX);

  logic        is_dec;
  logic [63:0] src;
  logic [63:0] sum;
  logic [63:0] term;
  tea_stage_t  data_next;

  // Pick the source word and the sum for this half round.
  // Encrypt updates a then b; decrypt updates b then a.
  always_comb begin
    is_dec = (in_data.op == TEA_OP_DECRYPT);
    sum    = is_dec ? SUM_DEC : SUM_ENC;
    if (SECOND ^ is_dec) begin
      src = in_data.a;
    end else begin
      src = in_data.b;
    end
    term = tea_term(src, sum, key);
  end

  // Add the term on encrypt, subtract it on decrypt.
  always_comb begin
    data_next = in_data;
    if (!is_dec) begin
      if (SECOND) begin
        data_next.b = in_data.b + term;
      end else begin
        data_next.a = in_data.a + term;
      end
    end else begin
      if (SECOND) begin
        data_next.a = in_data.a - term;
      end else begin
        data_next.b = in_data.b - term;
      end
    end
  end

  // Valid bit is control state; the payload register needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[design/tea_cipher_64bit_words.sv]
// Top level of the 64-bit TEA-style cipher: key register and round pipeline.
// Depends on tea_pkg and tea_half_round.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one block per item:
//   an op (encrypt or decrypt) and two 64-bit words. Output channel
//   out_valid / out_stall / out_data returns the two processed words.
//   The key is written through key_wr_en / key_wr_data while no item is
//   in flight; it is read by every stage directly.
// Pipeline:
//   Each round is split over two register stages, one per word update. One
//   item can enter every cycle while the output is not stalled; the stage
//   count is set by the two dependent 64-bit adds of each half round.
// Reset:
//   rst is synchronous and active high. It clears every stage valid bit and
//   sets the key to zero.
// Stall:
//   While out_valid is high and out_stall is high, the whole pipeline holds
//   and in_stall is raised; nothing is lost or repeated. When the output is
//   empty or taken, the pipeline advances and accepts a new item.
`default_nettype none

module tea_cipher_64bit_words
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire tea_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tea_out_t         out_data,
  input  wire logic        key_wr_en,
  input  wire logic [63:0] key_wr_data
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  logic [63:0]  key;
  logic         en;
  logic         stage_valid [0:STAGES];
  tea_stage_t   stage_data  [0:STAGES];

  // Key register, to be written only while the pipeline is empty; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (key_wr_en) begin
      key <= key_wr_data;
    end
  end

  // The pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage zero is the incoming item.
  assign stage_valid[0]   = in_valid;
  assign stage_data[0].op = in_data.op;
  assign stage_data[0].a  = in_data.first_half;
  assign stage_data[0].b  = in_data.second_half;

  // Two half-round stages per round.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    tea_half_round #(
      .ROUNDS    (ROUNDS),
      .ROUND_IDX (s / 2),
      .SECOND    (1'(s % 2))
    ) u_half_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .key       (key),
      .in_valid  (stage_valid[s]),
      .in_data   (stage_data[s]),
      .out_valid (stage_valid[s+1]),
      .out_data  (stage_data[s+1])
    );
  end

  // The last stage register is the output register.
  assign out_valid           = stage_valid[STAGES];
  assign out_data.out_first  = stage_data[STAGES].a;
  assign out_data.out_second = stage_data[STAGES].b;

endmodule

`default_nettype wire

[design/tea_checker.sv]
// Port-level assertions for the cipher top level, attached with a bind.
// Depends on tea_pkg for the payload types and on tea_cipher_64bit_words.
`default_nettype none

module tea_checker
  import tea_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire tea_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tea_out_t out_data
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // The input side only stalls when a result is held at the output.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output item");

  // A held output always holds back the input side.
  a_stall_prop: assert property (@(posedge clk)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output item held");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Keep otherwise unchecked inputs referenced.
  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

endmodule

bind tea_cipher_64bit_words tea_checker u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
